>>> sv/assert_macros.svh
// Assertion macros shared by the band signal RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define BBTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BBTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/bbts_pkg.sv
// Shared types and constants of the Bollinger band trade signal block.
// No dependencies.
package bbts_pkg;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int PRICE_BITS_DEF = 24;
  localparam int PRICE_W = 24;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int WL_W = 9;
  localparam int BM_W = 12;
  localparam int K2_W = 2 * BM_W;
  localparam logic [WL_W-1:0] WL_RESET = 9'd20;
  localparam logic [BM_W-1:0] BM_RESET = 12'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_BAND_MULTIPLIER = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQSUM,
    B_NSQ,
    B_VAR,
    B_DEV,
    B_EMIT
  } back_state_t;
endpackage

>>> sv/bollinger_band_trade_signal_top.sv
// Bollinger band trade signal: each price item yields one hold, buy or sell result.
// The front end steps through its read and push states per item; the back end runs
// the band test on a shared shift-and-add multiplier, four products in turn, each
// over BW multiplier bits (BW is the larger of the sum width and 24, 33 at the
// default parameters). An item in a filling window skips the multiplier, so the
// serial multiplier sets the sustained rate for full windows. A two-entry queue
// lets the front end keep taking items while the back end works.
// Depends on bbts_pkg, bbts_front, bbts_queue and bbts_back.
module bollinger_band_trade_signal_top import bbts_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PRICE_W-1:0]    in_price,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_action,
  output logic                  out_window_ready,
  output logic                  out_trade_won,
  output logic [31:0]           out_trades_total,
  output logic [31:0]           out_trades_winning,
  output logic [31:0]           out_trades_losing,
  output logic [31:0]           out_window_sum,
  output logic [55:0]           out_window_sum_squares,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = PRICE_BITS + LW;
  localparam int QW = 2 * PRICE_BITS + LW;
  localparam int EW = PRICE_BITS + 2 * SW + QW + LW + 1;

  logic [WL_W-1:0] wl_r;
  logic [BM_W-1:0] bm_r;
  logic [LW-1:0]   win_len;
  logic            restart;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [EW-1:0]   q_wdata;
  logic [EW-1:0]   q_rdata;

  assign restart = cfg_we && (cfg_index == CFG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= WL_RESET;
      bm_r <= BM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        wl_r <= cfg_data[WL_W-1:0];
      end else if (cfg_index == CFG_BAND_MULTIPLIER) begin
        bm_r <= cfg_data[BM_W-1:0];
      end
    end
  end

  always_comb begin
    if (wl_r == '0) begin
      win_len = LW'(1);
    end else if (32'(wl_r) > WINDOW_MAX) begin
      win_len = LW'(WINDOW_MAX);
    end else begin
      win_len = LW'(wl_r);
    end
  end

  bbts_front #(.WINDOW_MAX(WINDOW_MAX), .PRICE_BITS(PRICE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_price(in_price),
    .restart (restart),
    .win_len (win_len),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  bbts_queue #(.W(EW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  bbts_back #(.WINDOW_MAX(WINDOW_MAX), .PRICE_BITS(PRICE_BITS)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .q_data                (q_rdata),
    .band_mult             (bm_r),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_action            (out_action),
    .out_window_ready      (out_window_ready),
    .out_trade_won         (out_trade_won),
    .out_trades_total      (out_trades_total),
    .out_trades_winning    (out_trades_winning),
    .out_trades_losing     (out_trades_losing),
    .out_window_sum        (out_window_sum),
    .out_window_sum_squares(out_window_sum_squares)
  );
endmodule

>>> sv/bbts_mult.sv
// Shift-and-add serial multiplier, one multiplier bit per cycle.
// Depends on bbts_pkg only by convention; used by bbts_back.
module bbts_mult import bbts_pkg::*; #(
  parameter int AW = 66,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int MW = AW + BW;
  localparam int CNT_W = $clog2(BW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MW-1:0]    acc_r;
  logic [MW-1:0]    a_r;
  logic [BW-1:0]    b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= MW'(a);
      b_r   <= b;
      cnt_r <= CNT_W'(BW - 1);
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

>>> sv/bbts_front.sv
// Front end: accepts prices, keeps the price ring and the running sums.
// Depends on bbts_pkg; pushes one record per item into bbts_queue.
module bbts_front import bbts_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int LW = $clog2(WINDOW_MAX + 1),
  parameter int SW = PRICE_BITS + LW,
  parameter int QW = 2 * PRICE_BITS + LW,
  parameter int EW = PRICE_BITS + 2 * SW + QW + LW + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PRICE_W-1:0] in_price,
  input  logic               restart,
  input  logic [LW-1:0]      win_len,
  output logic               q_push,
  output logic [EW-1:0]      q_data,
  input  logic               q_full
);
  localparam int AW = $clog2(WINDOW_MAX);

  front_state_t          state_r, state_nxt;
  logic [AW-1:0]         ptr_r;
  logic [LW-1:0]         fill_r;
  logic [SW-1:0]         sum_r;
  logic [QW-1:0]         sumsq_r;
  logic [PRICE_BITS-1:0] p_r;
  logic [PRICE_BITS-1:0] old_r;
  logic [2*PRICE_BITS-1:0] psq_r;
  logic [2*PRICE_BITS-1:0] oldsq_r;
  logic [SW-1:0]         np_r;
  logic [PRICE_BITS-1:0] ring [WINDOW_MAX];

  logic                  accept;
  logic                  full_win;
  logic [LW-1:0]         fill_nxt;
  logic [SW-1:0]         sum_nxt;
  logic [QW-1:0]         sumsq_nxt;
  logic                  ready_nxt;
  logic [LW:0]           ptr_inc;
  logic [AW-1:0]         ptr_nxt;

  assign accept = (state_r == F_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != F_IDLE);
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_READ;
        end
      end
      F_READ: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    full_win  = (fill_r >= win_len);
    fill_nxt  = full_win ? fill_r : fill_r + 1'b1;
    sum_nxt   = sum_r - (full_win ? SW'(old_r) : '0) + SW'(p_r);
    sumsq_nxt = sumsq_r - (full_win ? QW'(oldsq_r) : '0) + QW'(psq_r);
    ready_nxt = (fill_nxt >= win_len);
    ptr_inc   = (LW + 1)'(ptr_r) + 1'b1;
    ptr_nxt   = (ptr_inc >= (LW + 1)'(win_len)) ? '0 : AW'(ptr_inc);
  end

  assign q_data = {p_r, np_r, sum_nxt, sumsq_nxt, win_len, ready_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ptr_r   <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (q_push) begin
      ptr_r   <= ptr_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r   <= in_price[PRICE_BITS-1:0];
      psq_r <= in_price[PRICE_BITS-1:0] * in_price[PRICE_BITS-1:0];
    end
    if (state_r == F_READ) begin
      oldsq_r <= old_r * old_r;
      np_r    <= SW'(win_len) * SW'(p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_r <= ring[ptr_r];
    end
    if (q_push) begin
      ring[ptr_r] <= p_r;
    end
  end
endmodule

>>> sv/bbts_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on bbts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bbts_queue import bbts_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  logic [W-1:0] entry_r [2];
  logic         wr_r;
  logic         rd_r;
  logic [1:0]   count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_data;
    end
  end

  `BBTS_ASSERT_IMPL(a_no_overflow, push && !pop, !full, "queue overflow")
  `BBTS_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue underflow")
  `BBTS_ASSERT_IMPL(a_count_bounded, 1'b1, count_r != 2'd3, "queue count out of range")
endmodule

>>> sv/bbts_back.sv
// Back end: band test on a serial multiplier, trade state and result register.
// Depends on bbts_pkg, bbts_mult and assert_macros.svh.
`include "assert_macros.svh"
module bbts_back import bbts_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int LW = $clog2(WINDOW_MAX + 1),
  parameter int SW = PRICE_BITS + LW,
  parameter int QW = 2 * PRICE_BITS + LW,
  parameter int EW = PRICE_BITS + 2 * SW + QW + LW + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic [EW-1:0]   q_data,
  input  logic [BM_W-1:0] band_mult,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_action,
  output logic            out_window_ready,
  output logic            out_trade_won,
  output logic [31:0]     out_trades_total,
  output logic [31:0]     out_trades_winning,
  output logic [31:0]     out_trades_losing,
  output logic [31:0]     out_window_sum,
  output logic [55:0]     out_window_sum_squares
);
  localparam int VW = QW + LW;
  localparam int BW = (SW > K2_W) ? SW : K2_W;
  localparam int MW = VW + BW;
  localparam int CW = MW + 16;

  back_state_t           state_r, state_nxt;
  logic [PRICE_BITS-1:0] q_p;
  logic [SW-1:0]         q_np;
  logic [SW-1:0]         q_sum;
  logic [QW-1:0]         q_sumsq;
  logic [LW-1:0]         q_n;
  logic                  q_rdy;

  logic [PRICE_BITS-1:0] p_r;
  logic [SW-1:0]         sum_r;
  logic [QW-1:0]         sumsq_r;
  logic [LW-1:0]         n_r;
  logic                  rdy_r;
  logic [SW-1:0]         d_r;
  logic                  below_r;
  logic                  above_r;
  logic [K2_W-1:0]       k2_r;
  logic [MW-1:0]         m1_r;
  logic [CW-1:0]         rhs_r;
  logic [CW-1:0]         lhs_r;

  logic                  holding_r;
  logic [PRICE_BITS-1:0] entry_r;
  logic [31:0]           total_r;
  logic [31:0]           wins_r;
  logic [31:0]           losses_r;

  logic                  out_valid_r;
  logic [1:0]            out_action_r;
  logic                  out_ready_r;
  logic                  out_won_r;
  logic [31:0]           out_sum_r;
  logic [55:0]           out_sumsq_r;

  logic                  mul_start;
  logic [VW-1:0]         mul_a;
  logic [BW-1:0]         mul_b;
  logic                  mul_done;
  logic [MW-1:0]         mul_prod;
  logic [VW-1:0]         var_w;
  logic                  out_ok;
  logic                  emit;
  logic                  beyond;
  logic                  do_buy;
  logic                  do_sell;
  logic                  won;

  assign {q_p, q_np, q_sum, q_sumsq, q_n, q_rdy} = q_data;
  assign var_w  = VW'(mul_prod - m1_r);
  assign out_ok = !out_valid_r || !out_stall;
  assign beyond = (lhs_r > rhs_r);
  assign do_buy  = rdy_r && !holding_r && below_r && beyond;
  assign do_sell = rdy_r && holding_r && above_r && beyond;
  assign won     = do_sell && (p_r > entry_r);

  bbts_mult #(.AW(VW), .BW(BW)) u_mult (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mul_start = 1'b0;
    mul_a     = VW'(q_sum);
    mul_b     = BW'(q_sum);
    emit      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mul_start = q_rdy;
          state_nxt = q_rdy ? B_SQSUM : B_EMIT;
        end
      end
      B_SQSUM: begin
        mul_a = VW'(sumsq_r);
        mul_b = BW'(n_r);
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = B_NSQ;
        end
      end
      B_NSQ: begin
        mul_a = var_w;
        mul_b = BW'(k2_r);
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = B_VAR;
        end
      end
      B_VAR: begin
        mul_a = VW'(d_r);
        mul_b = BW'(d_r);
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = B_DEV;
        end
      end
      B_DEV: begin
        if (mul_done) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_ok) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_r     <= q_p;
      sum_r   <= q_sum;
      sumsq_r <= q_sumsq;
      n_r     <= q_n;
      rdy_r   <= q_rdy;
      below_r <= (q_sum > q_np);
      above_r <= (q_np > q_sum);
      d_r     <= (q_sum > q_np) ? q_sum - q_np : q_np - q_sum;
      k2_r    <= band_mult * band_mult;
    end
    if (mul_done) begin
      unique case (state_r)
        B_SQSUM: m1_r  <= mul_prod;
        B_VAR:   rhs_r <= CW'(mul_prod);
        B_DEV:   lhs_r <= CW'(mul_prod) << 16;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r   <= 1'b0;
      entry_r     <= '0;
      total_r     <= '0;
      wins_r      <= '0;
      losses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit && do_buy) begin
        holding_r <= 1'b1;
        entry_r   <= p_r;
      end
      if (emit && do_sell) begin
        holding_r <= 1'b0;
        total_r   <= (total_r == '1) ? total_r : total_r + 1'b1;
        if (won) begin
          wins_r <= (wins_r == '1) ? wins_r : wins_r + 1'b1;
        end else begin
          losses_r <= (losses_r == '1) ? losses_r : losses_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r <= do_buy ? ACT_BUY : (do_sell ? ACT_SELL : ACT_HOLD);
      out_ready_r  <= rdy_r;
      out_won_r    <= won;
      out_sum_r    <= 32'(sum_r);
      out_sumsq_r  <= 56'(sumsq_r);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_action             = out_action_r;
  assign out_window_ready       = out_ready_r;
  assign out_trade_won          = out_won_r;
  assign out_trades_total       = total_r;
  assign out_trades_winning     = wins_r;
  assign out_trades_losing      = losses_r;
  assign out_window_sum         = out_sum_r;
  assign out_window_sum_squares = out_sumsq_r;

  `BBTS_ASSERT_IMPL(a_signal_needs_window, out_valid_r && (out_action_r != ACT_HOLD), out_ready_r, "signal without full window")
  `BBTS_ASSERT_IMPL(a_won_only_on_sell, out_valid_r && out_won_r, out_action_r == ACT_SELL, "win flag without sell")
  `BBTS_ASSERT_NEXT(a_buy_opens_position, emit && do_buy, holding_r, "buy did not open a position")
endmodule

>>> test/bollinger_band_trade_signal_top_tb.sv
// Self-checking testbench for the Bollinger band trade signal block.
// A clocked driver and monitor with random idling compare each result with a local band predictor.
// Depends on bbts_pkg and bollinger_band_trade_signal_top.
`timescale 1ns / 1ps
module bollinger_band_trade_signal_top_tb;
  import bbts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    action_t     act;
    logic        ready;
    logic        won;
    logic [31:0] total;
    logic [31:0] winning;
    logic [31:0] losing;
    logic [31:0] sum;
    logic [55:0] sum_sq;
  } signal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PRICE_W-1:0] in_price = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_action;
  logic out_window_ready, out_trade_won;
  logic [31:0] out_trades_total, out_trades_winning, out_trades_losing, out_window_sum;
  logic [55:0] out_window_sum_squares;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [PRICE_W-1:0] pending_prices[$];
  signal_t expected_signals[$];
  bit failed = 0;
  int prices_taken = 0;
  int quiet_cycles = 0;

  logic [PRICE_W-1:0] ring[WINDOW_MAX_DEF];
  int unsigned ring_ptr, fill, trips, wins, losses, win_len, band_k;
  logic [63:0] run_sum, run_sq;
  logic holding;
  logic [PRICE_W-1:0] entry;

  bollinger_band_trade_signal_top uut (.*);

  always #1 clk = ~clk;

  function automatic int unsigned sat_up(int unsigned v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  task automatic predict_signal(input logic [PRICE_W-1:0] p);
    signal_t s;
    int unsigned n, idx;
    logic [63:0] old, np;
    logic [127:0] spread, rhs, dev, lhs;
    n = (win_len == 0) ? 1 : (win_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_len;
    idx = ring_ptr;
    if (fill >= n) begin
      old = ring[idx];
      run_sum -= old;
      run_sq -= old * old;
    end else begin
      fill++;
    end
    run_sum += 64'(p);
    run_sq += 64'(p) * 64'(p);
    ring[idx] = p;
    ring_ptr = (idx + 1 >= n) ? 0 : idx + 1;
    s.act = ACT_HOLD;
    s.ready = 1'b0;
    s.won = 1'b0;
    if (fill >= n) begin
      np = 64'(n) * 64'(p);
      spread = 128'(n) * 128'(run_sq) - 128'(run_sum) * 128'(run_sum);
      rhs = spread * 128'(band_k) * 128'(band_k);
      dev = (run_sum > np) ? 128'(run_sum - np) : 128'(np - run_sum);
      lhs = (dev * dev) << 16;
      s.ready = 1'b1;
      if (!holding && run_sum > np && lhs > rhs) begin
        s.act = ACT_BUY;
        holding = 1'b1;
        entry = p;
      end else if (holding && np > run_sum && lhs > rhs) begin
        s.act = ACT_SELL;
        holding = 1'b0;
        if (p > entry) begin
          s.won = 1'b1;
          wins = sat_up(wins);
        end else begin
          losses = sat_up(losses);
        end
        trips = sat_up(trips);
      end
    end
    s.total = trips;
    s.winning = wins;
    s.losing = losses;
    s.sum = run_sum[31:0];
    s.sum_sq = run_sq[55:0];
    expected_signals.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_prices.size() != 0 || in_valid || expected_signals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    if (idx == CFG_WINDOW_LENGTH) begin
      win_len = val & 9'h1FF;
      ring_ptr = 0;
      fill = 0;
      run_sum = '0;
      run_sq = '0;
    end else if (idx == CFG_BAND_MULTIPLIER) begin
      band_k = val & 12'hFFF;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_series(input int count);
    int level, r;
    level = $urandom_range(24'hFF_FFFF - 24'h10_0000, 24'h10_0000);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        pending_prices.push_back(PRICE_W'($urandom()));
      end else if (r < 9) begin
        pending_prices.push_back(($urandom_range(1) != 0) ? 24'hFF_FFFF : 24'h0);
      end else if (r < 22) begin
        pending_prices.push_back(PRICE_W'(level - $urandom_range(24'h0F_FFFF, 24'h1000)));
      end else if (r < 35) begin
        pending_prices.push_back(PRICE_W'(level + $urandom_range(24'h0F_FFFF, 24'h1000)));
      end else begin
        level = level + $urandom_range(4000) - 2000;
        if (level < 24'h10_0000) level = 24'h10_0000;
        if (level > 24'hEF_FFFF) level = 24'hEF_FFFF;
        pending_prices.push_back(PRICE_W'(level + $urandom_range(300)));
      end
    end
  endtask

  always @(posedge clk) begin
    int idle;
    idle = (prices_taken < 620) ? 33 : (prices_taken < 1240) ? 82 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_signal(in_price);
        prices_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_prices.size() != 0 && $urandom_range(99) >= idle) begin
          in_valid <= 1'b1;
          in_price <= pending_prices.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    signal_t e;
    int idle;
    idle = (prices_taken < 620) ? 82 : (prices_taken < 1240) ? 33 : 0;
    out_stall <= ($urandom_range(99) < idle);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_signals.size() == 0) begin
        $display("%0t: unexpected result, action %0d", $time, out_action);
        failed = 1;
      end else begin
        e = expected_signals.pop_front();
        if (out_action !== e.act || out_window_ready !== e.ready ||
            out_trade_won !== e.won || out_trades_total !== e.total ||
            out_trades_winning !== e.winning || out_trades_losing !== e.losing ||
            out_window_sum !== e.sum || out_window_sum_squares !== e.sum_sq) begin
          $display("%0t: mismatch expected act %0d rdy %0d won %0d tot %0d win %0d los %0d sum %0d sq %0d",
                   $time, e.act, e.ready, e.won, e.total, e.winning, e.losing, e.sum, e.sum_sq);
          $display("%0t:          actual act %0d rdy %0d won %0d tot %0d win %0d los %0d sum %0d sq %0d",
                   $time, out_action, out_window_ready, out_trade_won, out_trades_total,
                   out_trades_winning, out_trades_losing, out_window_sum,
                   out_window_sum_squares);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bollinger_band_trade_signal_top");
      $finish;
    end
  end

  initial begin
    int unsigned lens[10] = '{3, 20, 256, 0, 1, 511, 5, 2, 8, 20};
    int unsigned mults[10] = '{0, 512, 384, 4095, 300, 200, 256, 1, 640, 512};
    int counts[10] = '{120, 300, 320, 60, 60, 300, 200, 100, 200, 170};
    ring_ptr = 0;
    fill = 0;
    run_sum = '0;
    run_sq = '0;
    holding = 1'b0;
    entry = '0;
    trips = 0;
    wins = 0;
    losses = 0;
    win_len = WL_RESET;
    band_k = BM_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_WINDOW_LENGTH, 4);
    write_reg(CFG_BAND_MULTIPLIER, 0);
    pending_prices = '{24'h0, 24'hFF_FFFF, 24'hFF_FFFF, 24'h0, 24'h0, 24'hFF_FFFF,
                       24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h10,
                       24'h80_0000, 24'hFF_FFF0, 24'h55_5555, 24'hAA_AAAA, 24'h80_0000,
                       24'h80_0000, 24'h7F_0000, 24'h90_0000, 24'h7F_0000, 24'h7E_0000};
    wait_idle();
    write_reg(CFG_SPARE_A, 12'hFFF);
    write_reg(CFG_SPARE_B, 12'h155);
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_WINDOW_LENGTH, lens[ph]);
      write_reg(CFG_BAND_MULTIPLIER, mults[ph]);
      queue_series(counts[ph]);
      wait_idle();
    end

    if (!failed)
      $display("PASS bollinger_band_trade_signal_top");
    else
      $display("FAIL bollinger_band_trade_signal_top");
    $finish;
  end
endmodule
